[src/ellipse_scanline_span_core_defines.svh]
// ----------------------------------------------------------------------------
// ellipse_scanline_span_core_defines.svh
// Assertion macros shared by the ellipse span core.
// ----------------------------------------------------------------------------
`ifndef ELLIPSE_SCANLINE_SPAN_CORE_DEFINES_SVH
`define ELLIPSE_SCANLINE_SPAN_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define ESS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle.
`define ESS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ess_pkg.sv]
// ----------------------------------------------------------------------------
// ess_pkg
// Types and constants of the ellipse scanline span core.
// ----------------------------------------------------------------------------
`default_nettype none

package ess_pkg;

    localparam int D_W   = 6;   // half-width bits, one cell each
    localparam int RY2_W = 12;
    localparam int P_W   = 18;  // d * ry^2
    localparam int REM_W = 24;  // rx^2 * (ry^2 - dy^2) minus d^2 * ry^2
    localparam int ACC_W = 26;

    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_X     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS_X     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS_Y     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PANEL_WIDTH  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_PANEL_HEIGHT = 3'd5;

    localparam logic [6:0] RST_CENTER_X     = 7'd64;
    localparam logic [6:0] RST_CENTER_Y     = 7'd71;
    localparam logic [5:0] RST_RADIUS_X     = 6'd28;
    localparam logic [5:0] RST_RADIUS_Y     = 6'd32;
    localparam logic [7:0] RST_PANEL_WIDTH  = 8'd128;
    localparam logic [7:0] RST_PANEL_HEIGHT = 8'd128;

    typedef struct packed {
        logic [6:0] center_x;
        logic [6:0] center_y;
        logic [5:0] radius_x;
        logic [5:0] radius_y;
        logic [7:0] width_eff;
        logic [7:0] height_eff;
    } cfg_t;

    typedef struct packed {
        logic             valid;
        logic             ok;
        logic [15:0]      dy2;
        logic [RY2_W-1:0] ry2;
        logic [RY2_W-1:0] rx2;
        logic [5:0]       rx;
        logic [6:0]       y;
        logic [15:0]      color;
    } front_t;

    typedef struct packed {
        logic             valid;
        logic             ok;
        logic [D_W-1:0]   d;
        logic [P_W-1:0]   p;
        logic [REM_W-1:0] rem;
        logic [RY2_W-1:0] ry2;
        logic [5:0]       rx;
        logic [6:0]       y;
        logic [15:0]      color;
    } cell_t;

endpackage

`default_nettype wire

[src/ess_stream_if.sv]
// ----------------------------------------------------------------------------
// ess_stream_if
// Valid/ready channels for row requests and span results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ess_in_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] row;
    logic [15:0]       fill_color;

    modport source (output valid, output row, output fill_color, input ready);
    modport sink   (input valid, input row, input fill_color, output ready);
endinterface

interface ess_out_if;
    logic        valid;
    logic        ready;
    logic        span_valid;
    logic [6:0]  span_x;
    logic [6:0]  span_y;
    logic [7:0]  span_width;
    logic [15:0] span_color;

    modport source (output valid, output span_valid, output span_x, output span_y,
                    output span_width, output span_color, input ready);
    modport sink   (input valid, input span_valid, input span_x, input span_y,
                    input span_width, input span_color, output ready);
endinterface

`default_nettype wire

[src/ellipse_scanline_span_core.sv]
// ----------------------------------------------------------------------------
// ellipse_scanline_span_core
// One horizontal fill span of a filled ellipse for each requested row.
// ----------------------------------------------------------------------------
// A row word is accepted in any cycle the result side is not stalled, and its
// span word passes through two front stages (row check, squares, target), a
// chain of six cells that each settle one bit of the half-width, and the
// output register. One row per cycle is sustained while the output is not
// stalled; a stalled output word freezes the whole chain and drops in_ch.ready.
// No clearing pass is needed after reset. Registers sit at byte addresses 4*i over APB.
`default_nettype none

module ellipse_scanline_span_core #(
    parameter int unsigned PANEL_SIZE = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    ess_in_if.sink           in_ch,
    ess_out_if.source        out_ch
);
    import ess_pkg::*;

`include "ellipse_scanline_span_core_defines.svh"

    logic [6:0]           center_x_reg;
    logic [6:0]           center_y_reg;
    logic [5:0]           radius_x_reg;
    logic [5:0]           radius_y_reg;
    logic [7:0]           panel_width_reg;
    logic [7:0]           panel_height_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    cfg_t                 cfg;
    logic                 advance;
    cell_t                chain [0:D_W];

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= RST_CENTER_X;
            center_y_reg     <= RST_CENTER_Y;
            radius_x_reg     <= RST_RADIUS_X;
            radius_y_reg     <= RST_RADIUS_Y;
            panel_width_reg  <= RST_PANEL_WIDTH;
            panel_height_reg <= RST_PANEL_HEIGHT;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_CENTER_X:     center_x_reg     <= pwdata[6:0];
                REG_CENTER_Y:     center_y_reg     <= pwdata[6:0];
                REG_RADIUS_X:     radius_x_reg     <= pwdata[5:0];
                REG_RADIUS_Y:     radius_y_reg     <= pwdata[5:0];
                REG_PANEL_WIDTH:  panel_width_reg  <= pwdata[7:0];
                REG_PANEL_HEIGHT: panel_height_reg <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CENTER_X:     prdata = 32'(center_x_reg);
            REG_CENTER_Y:     prdata = 32'(center_y_reg);
            REG_RADIUS_X:     prdata = 32'(radius_x_reg);
            REG_RADIUS_Y:     prdata = 32'(radius_y_reg);
            REG_PANEL_WIDTH:  prdata = 32'(panel_width_reg);
            REG_PANEL_HEIGHT: prdata = 32'(panel_height_reg);
            default:          prdata = 32'd0;
        endcase
    end

    // Cap the panel at the supported size; the capped value never exceeds the register.
    always_comb
    begin
        cfg.center_x   = center_x_reg;
        cfg.center_y   = center_y_reg;
        cfg.radius_x   = radius_x_reg;
        cfg.radius_y   = radius_y_reg;
        cfg.width_eff  = (32'(panel_width_reg) > PANEL_SIZE) ? 8'(PANEL_SIZE)
                                                             : panel_width_reg;
        cfg.height_eff = (32'(panel_height_reg) > PANEL_SIZE) ? 8'(PANEL_SIZE)
                                                              : panel_height_reg;
    end

    assign in_ch.ready = advance;

    ess_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .cfg        (cfg),
        .in_valid   (in_ch.valid),
        .row        (in_ch.row),
        .fill_color (in_ch.fill_color),
        .cell_out   (chain[0])
    );

    for (genvar g = 0; g < D_W; g++)
    begin : g_cell
        ess_cell #(
            .BIT (D_W - 1 - g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .advance  (advance),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    ess_span u_span (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cell_in (chain[D_W]),
        .advance (advance),
        .out_ch  (out_ch)
    );

    `ESS_ASSERT_SAME(a_stall_blocks_input, out_ch.valid && !out_ch.ready, !in_ch.ready, "input taken during output stall")
    `ESS_ASSERT_SAME(a_invalid_zero, out_ch.valid && !out_ch.span_valid, (out_ch.span_x == 7'd0) && (out_ch.span_y == 7'd0) && (out_ch.span_width == 8'd0) && (out_ch.span_color == 16'd0), "invalid span word carries data")
    `ESS_ASSERT_SAME(a_width_odd, out_ch.valid && out_ch.span_valid, out_ch.span_width[0], "span width is even")
    `ESS_ASSERT_SAME(a_span_on_panel, out_ch.valid && out_ch.span_valid, (9'(out_ch.span_x) + 9'(out_ch.span_width)) <= 9'(cfg.width_eff), "span passes panel edge")

endmodule

`default_nettype wire

[src/ess_front.sv]
// ----------------------------------------------------------------------------
// ess_front
// Row check, squares and the square-root target, in two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ess_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire ess_pkg::cfg_t     cfg,
    input  wire logic              in_valid,
    input  wire logic signed [8:0] row,
    input  wire logic [15:0]       fill_color,
    output ess_pkg::cell_t         cell_out
);
    import ess_pkg::*;

    front_t           a_reg;
    front_t           a_next;
    cell_t            b_reg;
    cell_t            b_next;
    logic [7:0]       row_u;
    logic             on_panel;
    logic [8:0]       dy;
    logic [7:0]       ady;
    logic             in_ellipse;
    logic [RY2_W-1:0] diff;
    logic [REM_W-1:0] target;

    always_comb
    begin
        row_u    = row[7:0];
        on_panel = !row[8] && (row_u < cfg.height_eff);
        dy       = {1'b0, row_u} - {2'b00, cfg.center_y};
        ady      = dy[8] ? 8'(9'd0 - dy) : dy[7:0];

        a_next.valid = in_valid;
        a_next.ok    = on_panel;
        a_next.dy2   = 16'(ady) * 16'(ady);
        a_next.ry2   = RY2_W'(cfg.radius_y) * RY2_W'(cfg.radius_y);
        a_next.rx2   = RY2_W'(cfg.radius_x) * RY2_W'(cfg.radius_x);
        a_next.rx    = cfg.radius_x;
        a_next.y     = row_u[6:0];
        a_next.color = fill_color;
    end

    // A zero vertical radius leaves only the centre row, where the target is
    // zero and the cells settle on d = rx.
    always_comb
    begin
        in_ellipse = a_reg.dy2 <= {4'd0, a_reg.ry2};
        diff       = a_reg.ry2 - a_reg.dy2[RY2_W-1:0];
        target     = REM_W'(a_reg.rx2) * REM_W'(diff);

        b_next.valid = a_reg.valid;
        b_next.ok    = a_reg.ok && in_ellipse;
        b_next.d     = '0;
        b_next.p     = '0;
        b_next.rem   = target;
        b_next.ry2   = a_reg.ry2;
        b_next.rx    = a_reg.rx;
        b_next.y     = a_reg.y;
        b_next.color = a_reg.color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
        end
        else if (advance)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    assign cell_out = b_reg;

endmodule

`default_nettype wire

[src/ess_cell.sv]
// ----------------------------------------------------------------------------
// ess_cell
// One bit of the half-width: try setting BIT and keep it if it still fits.
// ----------------------------------------------------------------------------
`default_nettype none

module ess_cell #(
    parameter int BIT = 0
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire ess_pkg::cell_t cell_in,
    output ess_pkg::cell_t      cell_out
);
    import ess_pkg::*;

    localparam logic [D_W-1:0] MASK = D_W'(1) << BIT;

    cell_t            cell_reg;
    cell_t            cell_next;
    logic [D_W-1:0]   trial;
    logic [ACC_W-1:0] inc;
    logic             fits;

    // (d + 2^k)^2 ry^2 - d^2 ry^2 = 2^(k+1) d ry^2 + 2^(2k) ry^2, with p = d ry^2
    always_comb
    begin
        trial = cell_in.d | MASK;
        inc   = (ACC_W'(cell_in.p) << (BIT + 1)) + (ACC_W'(cell_in.ry2) << (2 * BIT));
        fits  = (trial <= cell_in.rx) && (inc <= ACC_W'(cell_in.rem));

        cell_next = cell_in;
        if (fits)
        begin
            cell_next.d   = trial;
            cell_next.p   = cell_in.p + (P_W'(cell_in.ry2) << BIT);
            cell_next.rem = cell_in.rem - REM_W'(inc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else if (advance)
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

`default_nettype wire

[src/ess_span.sv]
// ----------------------------------------------------------------------------
// ess_span
// Span placement, clip check and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ess_span (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ess_pkg::cfg_t  cfg,
    input  wire ess_pkg::cell_t cell_in,
    output logic                advance,
    ess_out_if.source           out_ch
);
    import ess_pkg::*;

    logic        vld_reg;
    logic        sv_reg;
    logic [6:0]  x_reg;
    logic [6:0]  y_reg;
    logic [7:0]  w_reg;
    logic [15:0] c_reg;
    logic [7:0]  x;
    logic [7:0]  w;
    logic [8:0]  right;
    logic        ok;

    always_comb
    begin
        x     = {1'b0, cfg.center_x} - {2'b00, cell_in.d};
        w     = {1'b0, cell_in.d, 1'b1};
        right = 9'(x[6:0]) + 9'(w);
        ok    = cell_in.ok && !x[7] && (right <= 9'(cfg.width_eff));
    end

    // Stall the whole chain while a word waits at the output.
    assign advance = !vld_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg <= cell_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sv_reg <= ok;
            x_reg  <= ok ? x[6:0] : 7'd0;
            y_reg  <= ok ? cell_in.y : 7'd0;
            w_reg  <= ok ? w : 8'd0;
            c_reg  <= ok ? cell_in.color : 16'd0;
        end
    end

    assign out_ch.valid      = vld_reg;
    assign out_ch.span_valid = sv_reg;
    assign out_ch.span_x     = x_reg;
    assign out_ch.span_y     = y_reg;
    assign out_ch.span_width = w_reg;
    assign out_ch.span_color = c_reg;

endmodule

`default_nettype wire

[verif/ellipse_scanline_span_checker.sv]
// ----------------------------------------------------------------------------
// ellipse_scanline_span_checker
// Watches the register port and both word channels of the span core, keeps
// its own copy of the ellipse and panel settings, predicts one span word for
// every accepted row word and compares the span words in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module ellipse_scanline_span_checker #(
    parameter int PANEL_SIZE = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    ess_in_if                in_mon,
    ess_out_if               out_mon,
    output int               mismatches,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ess_pkg::*;

    typedef struct {
        logic        span_valid;
        logic [6:0]  x;
        logic [6:0]  y;
        logic [7:0]  width;
        logic [15:0] color;
        int          row;
    } span_t;

    logic [6:0] cx_q;
    logic [6:0] cy_q;
    logic [5:0] rx_q;
    logic [5:0] ry_q;
    logic [7:0] pw_q;
    logic [7:0] ph_q;

    span_t spans_due[$];

    task automatic report(input string msg);
        if (mismatches < 40)
            $display("ERROR %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want,
                               input int row);
        if (got != want)
            report($sformatf("row %0d: %s is %0d, expected %0d", row, name, got, want));
    endtask

    // Span of one row under the current settings; all fields zero if not drawn.
    function automatic span_t trace_span(input logic signed [8:0] r, input logic [15:0] c);
        span_t s;
        int    row_i;
        int    w_eff;
        int    h_eff;
        int    dy;
        int    ady;
        int    dy2;
        int    ry2;
        int    rx;
        int    d;
        int    target;
        int    x;
        int    w;
        bit    hit;

        s       = '{span_valid: 1'b0, x: '0, y: '0, width: '0, color: '0, row: 0};
        row_i   = r;
        s.row   = row_i;
        w_eff   = (int'(pw_q) > PANEL_SIZE) ? PANEL_SIZE : int'(pw_q);
        h_eff   = (int'(ph_q) > PANEL_SIZE) ? PANEL_SIZE : int'(ph_q);
        rx      = int'(rx_q);
        ry2     = int'(ry_q) * int'(ry_q);
        d       = 0;
        hit     = (row_i >= 0) && (row_i < h_eff);

        if (hit) begin
            dy  = row_i - int'(cy_q);
            ady = (dy < 0) ? -dy : dy;
            dy2 = ady * ady;
            if (ry_q == '0) begin
                // degenerate ellipse: only the centre row, full horizontal radius
                if (ady != 0)
                    hit = 1'b0;
                else
                    d = rx;
            end
            else if (dy2 > ry2) begin
                hit = 1'b0;
            end
            else begin
                target = rx * rx * (ry2 - dy2);
                while (d < rx && (d + 1) * (d + 1) * ry2 <= target)
                    d++;
            end
        end

        if (hit) begin
            x = int'(cx_q) - d;
            w = 2 * d + 1;
            // drop clipped spans rather than trim them
            if (x < 0 || x + w > w_eff)
                hit = 1'b0;
        end

        if (hit) begin
            s.span_valid = 1'b1;
            s.x          = x[6:0];
            s.y          = row_i[6:0];
            s.width      = w[7:0];
            s.color      = c;
        end
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        span_t want;
        if (!rst_n)
        begin
            cx_q    <= RST_CENTER_X;
            cy_q    <= RST_CENTER_Y;
            rx_q    <= RST_RADIUS_X;
            ry_q    <= RST_RADIUS_Y;
            pw_q    <= RST_PANEL_WIDTH;
            ph_q    <= RST_PANEL_HEIGHT;
            spans_due.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_CENTER_X:     cx_q <= pwdata[6:0];
                    REG_CENTER_Y:     cy_q <= pwdata[6:0];
                    REG_RADIUS_X:     rx_q <= pwdata[5:0];
                    REG_RADIUS_Y:     ry_q <= pwdata[5:0];
                    REG_PANEL_WIDTH:  pw_q <= pwdata[7:0];
                    REG_PANEL_HEIGHT: ph_q <= pwdata[7:0];
                    default: ;
                endcase
            end

            // retire before accepting, so a word never meets its own prediction
            if (out_mon.valid && out_mon.ready)
            begin
                if (spans_due.size() == 0)
                begin
                    report($sformatf("span word with nothing expected: valid %0d x %0d y %0d",
                                     out_mon.span_valid, out_mon.span_x, out_mon.span_y));
                end
                else
                begin
                    want = spans_due.pop_front();
                    check_field("span_valid", out_mon.span_valid, want.span_valid, want.row);
                    check_field("span_x", out_mon.span_x, want.x, want.row);
                    check_field("span_y", out_mon.span_y, want.y, want.row);
                    check_field("span_width", out_mon.span_width, want.width, want.row);
                    check_field("span_color", out_mon.span_color, want.color, want.row);
                end
            end

            if (in_mon.valid && in_mon.ready)
                spans_due.push_back(trace_span(in_mon.row, in_mon.fill_color));

            pending <= spans_due.size();
        end
    end

endmodule

`default_nettype wire

[verif/ellipse_scanline_span_core_tb.sv]
// ----------------------------------------------------------------------------
// ellipse_scanline_span_core_tb
// Drives row words into the span core under a series of ellipse and panel
// settings: edge rows and degenerate settings first, then random settings with
// rows mostly around the ellipse. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
`default_nettype none

module ellipse_scanline_span_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ess_pkg::*;

    localparam int          PANEL        = 128;
    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int          LONG_HOLD    = 400;
    localparam int          HOLD_AFTER   = 500;
    localparam int          TAIL_CYCLES  = 12;

    // indexes past the register file, writes there must change nothing
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_6 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED_7 = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          pending;
    int          rows_taken = 0;
    int          burst_left = 0;
    int          sh_cy;
    int          sh_ry;

    ess_in_if  in_ch();
    ess_out_if out_ch();

    ellipse_scanline_span_core #(
        .PANEL_SIZE(PANEL)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    ellipse_scanline_span_checker #(
        .PANEL_SIZE(PANEL)
    ) span_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            rows_taken <= rows_taken + 1;
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // Result side: stall patterns in segments, plus one long hold-off mid-run.
    initial
    begin : result_sink
        int mode;
        int seg;
        int hold;
        bit held;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(16, 96);
            repeat (seg)
            begin
                @(posedge clk);
                if (!held && rows_taken >= HOLD_AFTER && in_ch.valid)
                begin
                    // hold off until the core backs up into its input
                    held = 1'b1;
                    out_ch.ready <= 1'b0;
                    for (hold = 0; hold < LONG_HOLD; hold++)
                        @(posedge clk);
                end
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= $urandom_range(0, 1);
                    2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= ~out_ch.ready;
                endcase
            end
        end
    end

    task automatic offer(input logic signed [8:0] r, input logic [15:0] c);
        int gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 3))
                0:       gap = 0;
                1:       gap = $urandom_range(1, 2);
                2:       gap = $urandom_range(3, 8);
                default: gap = $urandom_range(9, 20);
            endcase
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_ch.valid      <= 1'b1;
        in_ch.row        <= r;
        in_ch.fill_color <= c;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every span word has come back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] v);
        logic [31:0] data;
        data = $urandom();
        case (idx)
            REG_CENTER_X, REG_CENTER_Y: data[6:0] = v[6:0];
            REG_RADIUS_X, REG_RADIUS_Y: data[5:0] = v[5:0];
            default:                    data[7:0] = v;
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_cfg(input int cx, input int cy, input int rx, input int ry,
                            input int pw, input int ph);
        drain();
        set_reg(REG_CENTER_X, cx[7:0]);
        set_reg(REG_CENTER_Y, cy[7:0]);
        set_reg(REG_RADIUS_X, rx[7:0]);
        set_reg(REG_RADIUS_Y, ry[7:0]);
        set_reg(REG_PANEL_WIDTH, pw[7:0]);
        set_reg(REG_PANEL_HEIGHT, ph[7:0]);
        sh_cy = cy;
        sh_ry = ry;
    endtask

    function automatic int panel_extent();
        case ($urandom_range(0, 4))
            0:       return PANEL;
            1:       return $urandom_range(0, 255);
            2:       return $urandom_range(96, 128);
            3:       return $urandom_range(129, 255);
            default: return $urandom_range(0, 2);
        endcase
    endfunction

    task automatic random_cfg();
        int cx;
        int rx;
        int ry;
        ry = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 63);
        if ($urandom_range(0, 1) != 0)
        begin
            // keep the ellipse on the panel so most spans are drawn
            rx = $urandom_range(0, 40);
            cx = rx + $urandom_range(0, 127 - 2 * rx);
        end
        else
        begin
            rx = $urandom_range(0, 63);
            cx = $urandom_range(0, 127);
        end
        load_cfg(cx, $urandom_range(0, 127), rx, ry, panel_extent(), panel_extent());
    endtask

    task automatic random_rows(input int count);
        int k;
        int r;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 3) != 0)
                r = sh_cy - sh_ry - 2 + int'($urandom_range(0, 2 * sh_ry + 4));
            else
                r = $urandom_range(0, 511);
            offer(r[8:0], $urandom_range(0, 65535));
        end
    endtask

    initial
    begin : stimulus
        int          edge_rows [12];
        logic [15:0] edge_colors [4];
        int          k;

        edge_rows   = '{-256, -128, -1, 0, 38, 39, 71, 103, 104, 127, 128, 255};
        edge_colors = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA};

        in_ch.valid      <= 1'b0;
        in_ch.row        <= '0;
        in_ch.fill_color <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        sh_cy = RST_CENTER_Y;
        sh_ry = RST_RADIUS_Y;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: off-panel rows, ellipse top/bottom edges, centre row
        for (k = 0; k < 12; k++)
            offer(edge_rows[k][8:0], edge_colors[k % 4]);

        // zero vertical radius: only the centre row is drawn
        load_cfg(20, 10, 5, 0, 128, 128);
        offer(9'sd10, 16'h1234);
        offer(9'sd9, 16'hFEDC);
        offer(9'sd11, 16'h0F0F);

        // left clip at the centre row and near the pole, a narrow span at the pole
        load_cfg(3, 64, 20, 20, 128, 128);
        offer(9'sd64, 16'hF800);
        offer(9'sd44, 16'h07E0);
        offer(9'sd50, 16'h001F);

        // panel registers above the core's size are capped
        load_cfg(64, 120, 63, 10, 255, 200);
        offer(9'sd120, 16'hC3A5);
        offer(9'sd127, 16'h3C5A);
        offer(9'sd128, 16'h8001);

        // full-width span now clipped on the right
        load_cfg(64, 120, 63, 10, 127, 200);
        offer(9'sd120, 16'h7FFE);

        // empty panel
        load_cfg(64, 120, 63, 10, 0, 0);
        offer(9'sd120, 16'hBEEF);
        offer(9'sd0, 16'h4321);

        // writes past the register file leave the settings alone
        load_cfg(RST_CENTER_X, RST_CENTER_Y, RST_RADIUS_X, RST_RADIUS_Y,
                 RST_PANEL_WIDTH, RST_PANEL_HEIGHT);
        set_reg(REG_UNMAPPED_6, $urandom_range(0, 255));
        set_reg(REG_UNMAPPED_7, $urandom_range(0, 255));
        offer(9'sd71, 16'h2468);

        load_cfg(0, 0, 0, 0, 0, 0);
        random_rows(50);
        load_cfg(127, 127, 63, 63, 255, 255);
        random_rows(50);

        for (k = 0; k < 11; k++)
        begin
            random_cfg();
            random_rows(100);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
